/* rtl/lkc_pkg.sv */
// ----------------------------------------------------------------------------
// lkc_pkg: shared constants for the lru key cache tag store
// widths of the request and response fields and the default store depth
// ----------------------------------------------------------------------------
package lkc_pkg;

   localparam int unsigned ENTRIES_DEF = 16;
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned SLOT_W      = 4;

endpackage

/* rtl/lkc_find_first.sv */
// ----------------------------------------------------------------------------
// lkc_find_first: lowest-index priority encoder
// reports whether any request bit is set and the index of the lowest one
// ----------------------------------------------------------------------------
module lkc_find_first #(
   parameter int unsigned WIDTH = lkc_pkg::ENTRIES_DEF,
   localparam int unsigned IDX_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] req_vec,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   always_comb begin
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (req_vec[i]) begin
            index = IDX_W'(i);
         end
      end
   end

   assign found = |req_vec;

endmodule

/* rtl/lru_key_cache_tags.sv */
// ----------------------------------------------------------------------------
// lru_key_cache_tags: fully associative key store with lru replacement
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    lookup_key[63:0], fill_ok
//   rsp_      out        rsp_valid/stall    hit, filled, slot[3:0],
//                                           evicted_valid, evicted_key[63:0]
//
// one request per cycle while rsp_ is not stalled; a request is registered,
// then looked up and the store updated while the response is loaded.
// the whole lookup (parallel key compare, priority encode, age update) sits
// between the request register and the response register.
// reset (synchronous) empties the store at once; no clearing pass.
// a stalled response holds the request register, which then stalls req_.
// ----------------------------------------------------------------------------
module lru_key_cache_tags #(
   parameter int unsigned ENTRIES = lkc_pkg::ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lkc_pkg::KEY_W-1:0]   req_lookup_key,
   input  logic                        req_fill_ok,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic                        rsp_filled,
   output logic [lkc_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                        rsp_evicted_valid,
   output logic [lkc_pkg::KEY_W-1:0]   rsp_evicted_key
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned AGE_W = IDX_W;
   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(ENTRIES - 1);

   // request register
   logic                      req_valid_ff;
   logic [lkc_pkg::KEY_W-1:0] req_key_ff;
   logic                      req_fill_ff;

   // store
   logic [lkc_pkg::KEY_W-1:0] entry_key_ff [ENTRIES];
   logic [ENTRIES-1:0]        entry_valid_ff, entry_valid_in;
   logic [AGE_W-1:0]          entry_age_ff [ENTRIES];
   logic [AGE_W-1:0]          entry_age_in [ENTRIES];

   // response register
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic                      rsp_filled_ff, rsp_filled_in;
   logic [lkc_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                      rsp_evicted_valid_ff, rsp_evicted_valid_in;
   logic [lkc_pkg::KEY_W-1:0] rsp_evicted_key_ff, rsp_evicted_key_in;

   logic                      advance;
   logic                      take_req;
   logic [ENTRIES-1:0]        match_vec;
   logic [ENTRIES-1:0]        victim_vec;
   logic [AGE_W-1:0]          hit_age;
   logic                      hit;
   logic                      free_found;
   logic                      victim_found;
   logic [IDX_W-1:0]          hit_idx;
   logic [IDX_W-1:0]          free_idx;
   logic [IDX_W-1:0]          victim_idx;
   logic [IDX_W-1:0]          fill_idx;
   logic                      store_full;
   logic                      do_fill;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign take_req  = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   // parallel key compare and victim detect
   always_comb begin
      hit_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i]  = entry_valid_ff[i] && (entry_key_ff[i] == req_key_ff);
         victim_vec[i] = entry_valid_ff[i] && (entry_age_ff[i] == AGE_OLDEST);
         // keys are distinct, so at most one entry contributes
         hit_age = hit_age | (match_vec[i] ? entry_age_ff[i] : '0);
      end
   end

   lkc_find_first #(.WIDTH(ENTRIES)) u_hit_enc (
      .req_vec (match_vec),
      .found   (hit),
      .index   (hit_idx)
   );

   lkc_find_first #(.WIDTH(ENTRIES)) u_free_enc (
      .req_vec (~entry_valid_ff),
      .found   (free_found),
      .index   (free_idx)
   );

   lkc_find_first #(.WIDTH(ENTRIES)) u_victim_enc (
      .req_vec (victim_vec),
      .found   (victim_found),
      .index   (victim_idx)
   );

   assign store_full = !free_found;
   assign do_fill    = !hit && req_fill_ff;
   assign fill_idx   = store_full ? victim_idx : free_idx;

   // next ages and valid bits
   always_comb begin
      entry_valid_in = entry_valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         entry_age_in[i] = entry_age_ff[i];
         if (hit) begin
            if (match_vec[i]) begin
               entry_age_in[i] = '0;
            end else if (entry_valid_ff[i] && (entry_age_ff[i] < hit_age)) begin
               entry_age_in[i] = entry_age_ff[i] + AGE_W'(1);
            end
         end else if (do_fill) begin
            if (IDX_W'(i) == fill_idx) begin
               entry_age_in[i] = '0;
               entry_valid_in[i] = 1'b1;
            end else if (entry_valid_ff[i]) begin
               entry_age_in[i] = entry_age_ff[i] + AGE_W'(1);
            end
         end
      end
   end

   // response fields
   always_comb begin
      rsp_hit_in           = 1'b0;
      rsp_filled_in        = 1'b0;
      rsp_slot_in          = '0;
      rsp_evicted_valid_in = 1'b0;
      rsp_evicted_key_in   = '0;
      if (hit) begin
         rsp_hit_in  = 1'b1;
         rsp_slot_in = lkc_pkg::SLOT_W'(hit_idx);
      end else if (do_fill) begin
         rsp_filled_in        = 1'b1;
         rsp_slot_in          = lkc_pkg::SLOT_W'(fill_idx);
         rsp_evicted_valid_in = store_full;
         rsp_evicted_key_in   = store_full ? entry_key_ff[victim_idx] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_age_ff[i] <= '0;
         end
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (take_req) begin
            entry_valid_ff <= entry_valid_in;
            for (int i = 0; i < ENTRIES; i++) begin
               entry_age_ff[i] <= entry_age_in[i];
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_key_ff  <= req_lookup_key;
         req_fill_ff <= req_fill_ok;
      end
      if (take_req) begin
         rsp_hit_ff           <= rsp_hit_in;
         rsp_filled_ff        <= rsp_filled_in;
         rsp_slot_ff          <= rsp_slot_in;
         rsp_evicted_valid_ff <= rsp_evicted_valid_in;
         rsp_evicted_key_ff   <= rsp_evicted_key_in;
      end
      if (take_req && do_fill) begin
         entry_key_ff[fill_idx] <= req_key_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_filled        = rsp_filled_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_key   = rsp_evicted_key_ff;

   // stored keys stay distinct
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |-> $onehot0(match_vec))
      else $error("more than one entry matches the request key");

   // a full store always has exactly one oldest entry
   a_victim_present: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && store_full) |-> (victim_found && $onehot(victim_vec)))
      else $error("full store without a unique oldest entry");

   // the store never shrinks
   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(entry_valid_ff) >= $past($countones(entry_valid_ff))))
      else $error("valid entry count dropped");

   // eviction only goes with a fill, never with a hit
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!(rsp_hit_ff && rsp_filled_ff)
                        && (!rsp_evicted_valid_ff || rsp_filled_ff)))
      else $error("inconsistent response flags");

endmodule
